[hdl/qwt_pkg.sv]
package qwt_pkg;

    // Byte codes that the tokenizer reacts to.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_V     = 8'h76;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_VT        = 8'h0B;

    localparam logic [7:0] COUNT_MAX     = 8'hFF;
    localparam logic [7:0] MAX_LEN_RESET = 8'hFF;

    typedef struct packed {
        logic       in_word;
        logic       single_quoted;
        logic       double_quoted;
        logic       escape_pending;
        logic [7:0] char_count;
    } t_word_state;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       word_end;
        logic [7:0] word_length;
    } t_result;

    localparam t_word_state WORD_STATE_CLEAR = '{
        in_word: 1'b0, single_quoted: 1'b0, double_quoted: 1'b0,
        escape_pending: 1'b0, char_count: 8'h00
    };

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [7:0] translate(input logic [7:0] c);
        logic [7:0] t;
        case (c)
            CH_LOW_N: t = CH_LF;
            CH_LOW_T: t = CH_TAB;
            CH_LOW_R: t = CH_CR;
            CH_LOW_B: t = CH_BS;
            CH_LOW_F: t = CH_FF;
            CH_LOW_V: t = CH_VT;
            default:  t = c;
        endcase
        return t;
    endfunction

endpackage

[hdl/quoted_word_tokenizer.sv]
// A request is held in the input register and its result then in the result register;
// one that yields a result waits there while the result register holds a stalled result.
// Throughput: one input byte per cycle unless a stalled result holds the input register;
// the word state updates in the same cycle that a byte leaves the input register, so no
// byte waits on the one before it. Reset (i_rst_n low, synchronous): both pipeline
// registers empty, word state cleared, and the word length limit back to 255.
module quoted_word_tokenizer #(
    parameter int MAX_WORD_LIMIT = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration: length limit register.
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    // Input request channel.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_line_end,
    // Result request channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_char_valid,
    output logic [7:0] o_out_char,
    output logic       o_word_end,
    output logic [7:0] o_word_length
);
    import qwt_pkg::*;

    // The limit can never exceed what the 8-bit count holds.
    localparam int         CAP_INT   = (MAX_WORD_LIMIT < 255) ? MAX_WORD_LIMIT : 255;
    localparam logic [7:0] LIMIT_CAP = CAP_INT[7:0];

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;
    logic [7:0]  r_max_len;
    t_word_state r_state;
    logic        r_out_valid;
    t_result     r_out;

    t_word_state n_state;
    t_result     n_out;
    logic        res_valid;
    logic [7:0]  limit;
    logic        out_free;
    logic        proc_fire;
    logic        in_accept;

    // Effective limit: configured value capped at the parameter, zero acting as one.
    always_comb begin
        limit = r_max_len;
        if (limit > LIMIT_CAP) begin
            limit = LIMIT_CAP;
        end
        if (limit == 8'd0) begin
            limit = 8'd1;
        end
    end

    qwt_step u_step (
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .i_limit     (limit),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_result    (n_out)
    );

    // A byte in the input register is consumed when its result, if any, has a
    // place to go. Bytes that produce nothing (skipped whitespace, quotes inside
    // a word) go through even while the result register is stalled.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_fire  = r_in_valid && (out_free || !res_valid);
    assign o_in_stall = r_in_valid && !proc_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input payload holds no control meaning, so it takes no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_in_char;
            r_in_last <= i_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    // The word state advances once per consumed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WORD_STATE_CLEAR;
        end else if (proc_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && res_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_char_valid  = r_out.char_valid;
    assign o_out_char    = r_out.out_char;
    assign o_word_end    = r_out.word_end;
    assign o_word_length = r_out.word_length;

    // An emitted character always counts toward its word.
    a_char_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_char_valid |-> o_word_length != 8'd0)
        else $error("emitted character with zero word length");

    // A result without a character only exists to close a word.
    a_bare_result_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_char_valid |-> o_word_end && (o_out_char == CH_NUL))
        else $error("result without character does not end a word");

    // No word grows past the capped limit.
    a_length_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_word_length <= LIMIT_CAP)
        else $error("word length beyond limit");

    // Outside a word all flags and the count are clear.
    a_idle_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.in_word |-> (r_state.char_count == 8'd0) && !r_state.single_quoted
            && !r_state.double_quoted && !r_state.escape_pending)
        else $error("stale word state while skipping whitespace");

endmodule

[hdl/qwt_step.sv]
module qwt_step (
    input  logic [7:0]          i_char,
    input  logic                i_last,
    input  logic [7:0]          i_limit,
    input  qwt_pkg::t_word_state i_state,
    output qwt_pkg::t_word_state o_state,
    output logic                o_res_valid,
    output qwt_pkg::t_result    o_result
);
    import qwt_pkg::*;

    logic       white;
    logic       skip;
    logic       emit;
    logic       word_done;
    logic [7:0] ch;
    logic [7:0] count_next;
    t_word_state upd;

    always_comb begin
        white      = is_white(i_char);
        skip       = !i_state.in_word && (i_char != CH_NUL) && white;
        emit       = 1'b0;
        word_done  = 1'b0;
        ch         = CH_NUL;
        upd        = i_state;
        upd.in_word = 1'b1;

        if (i_char == CH_NUL) begin
            word_done = 1'b1;
        end else if (i_state.escape_pending) begin
            upd.escape_pending = 1'b0;
            ch   = translate(i_char);
            emit = 1'b1;
        end else if (!i_state.single_quoted && !i_state.double_quoted && white) begin
            word_done = 1'b1;
        end else if (i_char == CH_BACKSLASH) begin
            upd.escape_pending = 1'b1;
        end else if (i_char == CH_SQUOTE) begin
            upd.single_quoted = !i_state.single_quoted;
        end else if (i_char == CH_DQUOTE) begin
            upd.double_quoted = !i_state.double_quoted;
        end else begin
            ch   = i_char;
            emit = 1'b1;
        end

        // The count saturates, then the limit check sees the updated value.
        count_next = i_state.char_count;
        if (emit && (i_state.char_count != COUNT_MAX)) begin
            count_next = i_state.char_count + 8'd1;
        end
        if (emit && (count_next >= i_limit)) begin
            word_done = 1'b1;
        end
        if (i_last) begin
            word_done = 1'b1;
        end
        upd.char_count = count_next;

        if (skip) begin
            o_res_valid = 1'b0;
            o_state     = i_last ? WORD_STATE_CLEAR : i_state;
        end else begin
            o_res_valid = emit || word_done;
            o_state     = word_done ? WORD_STATE_CLEAR : upd;
        end

        o_result.char_valid  = emit;
        o_result.out_char    = ch;
        o_result.word_end    = word_done;
        o_result.word_length = count_next;
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    import qwt_pkg::*;

    // The directed table: one raw byte per row, its line-end flag, and, where the
    // answer is obvious, the result the tokenizer has to give for it. Rows without
    // a typed answer are checked against the predictor like the random traffic.
    typedef struct packed {
        logic [7:0] in_char;
        logic       eol;
        logic       typed;
        t_result    want;
    } t_dir_row;

    localparam int N_DIR = 25;

    localparam t_dir_row [0:N_DIR-1] DIR_ROWS = {
        // in_char     eol   typed  chr_v out_char  w_end length
        {CH_SPACE,     1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0}, // leading blank, skipped
        {8'h61,        1'b0, 1'b1,  1'b1, 8'h61,    1'b0, 8'd1},
        {8'hFF,        1'b0, 1'b1,  1'b1, 8'hFF,    1'b0, 8'd2}, // top byte value
        {CH_SPACE,     1'b0, 1'b1,  1'b0, 8'h00,    1'b1, 8'd2}, // blank ends the word
        {CH_NUL,       1'b0, 1'b1,  1'b0, 8'h00,    1'b1, 8'd0}, // NUL outside a word
        {CH_DQUOTE,    1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_SPACE,     1'b0, 1'b1,  1'b1, CH_SPACE, 1'b0, 8'd1}, // blank kept in quotes
        {CH_SQUOTE,    1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0}, // both quote flags set
        {CH_CR,        1'b0, 1'b1,  1'b1, CH_CR,    1'b0, 8'd2},
        {CH_BACKSLASH, 1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_LOW_N,     1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_BACKSLASH, 1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_LOW_T,     1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_BACKSLASH, 1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_LOW_R,     1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_BACKSLASH, 1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_LOW_B,     1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_BACKSLASH, 1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_LOW_F,     1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_BACKSLASH, 1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_LOW_V,     1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_BACKSLASH, 1'b0, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0},
        {CH_NUL,       1'b0, 1'b1,  1'b0, 8'h00,    1'b1, 8'd8}, // escaped NUL still ends
        {CH_SQUOTE,    1'b1, 1'b1,  1'b0, 8'h00,    1'b1, 8'd0}, // quotes-only word at eol
        {CH_SPACE,     1'b1, 1'b0,  1'b0, 8'h00,    1'b0, 8'd0}  // skipped blank at eol
    };

    // The length limit in the block is capped by its parameter; the default is used.
    localparam int WORD_CAP = 255;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_in_char = 8'h00;
    logic       i_line_end = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_char_valid;
    logic [7:0] o_out_char;
    logic       o_word_end;
    logic [7:0] o_word_length;

    // Side information that travels with each request so that the checker knows
    // whether a directed row carries a typed answer.
    logic       row_typed = 1'b0;
    t_result    row_want = '0;

    quoted_word_tokenizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_char     (i_in_char),
        .i_line_end    (i_line_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_char_valid  (o_char_valid),
        .o_out_char    (o_out_char),
        .o_word_end    (o_word_end),
        .o_word_length (o_word_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs. The slowest legal run is far below this.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Word-splitting predictor. It keeps its own copy of the tokenizer state
    // and of the length limit, and is advanced once per accepted request.
    // ------------------------------------------------------------------------
    logic       tok_in_word;
    logic       tok_squote;
    logic       tok_dquote;
    logic       tok_escape;
    logic [7:0] tok_count;
    logic [7:0] tok_max_len;

    t_result    expected_tokens[$];
    int         mismatch_count = 0;

    function automatic logic blank_byte(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void clear_word_state();
        tok_in_word = 1'b0;
        tok_squote  = 1'b0;
        tok_dquote  = 1'b0;
        tok_escape  = 1'b0;
        tok_count   = 8'h00;
    endfunction

    // Returns 1 when the byte produces a result, which is then placed in tok.
    function automatic bit tokenize_byte(input logic [7:0] c, input logic eol,
                                         output t_result tok);
        bit         keep;
        bit         done;
        logic [7:0] ch;
        int         lim;
        keep = 1'b0;
        done = 1'b0;
        ch   = 8'h00;
        tok  = '0;

        // Blanks between words are swallowed; a line end there still wipes the state.
        if (!tok_in_word && c != CH_NUL && blank_byte(c)) begin
            if (eol)
                clear_word_state();
            return 1'b0;
        end
        tok_in_word = 1'b1;

        if (c == CH_NUL) begin
            done = 1'b1;
        end else if (tok_escape) begin
            tok_escape = 1'b0;
            keep = 1'b1;
            case (c)
                CH_LOW_N: ch = CH_LF;
                CH_LOW_T: ch = CH_TAB;
                CH_LOW_R: ch = CH_CR;
                CH_LOW_B: ch = CH_BS;
                CH_LOW_F: ch = CH_FF;
                CH_LOW_V: ch = CH_VT;
                default:  ch = c;
            endcase
        end else if (!tok_squote && !tok_dquote && blank_byte(c)) begin
            done = 1'b1;
        end else if (c == CH_BACKSLASH) begin
            tok_escape = 1'b1;
        end else if (c == CH_SQUOTE) begin
            tok_squote = !tok_squote;
        end else if (c == CH_DQUOTE) begin
            tok_dquote = !tok_dquote;
        end else begin
            ch = c;
            keep = 1'b1;
        end

        if (keep) begin
            lim = tok_max_len;
            if (lim > WORD_CAP)
                lim = WORD_CAP;
            if (lim == 0)
                lim = 1;
            if (tok_count != COUNT_MAX)
                tok_count = tok_count + 8'd1;
            if (tok_count >= lim)
                done = 1'b1;
        end
        if (eol)
            done = 1'b1;

        if (!keep && !done)
            return 1'b0;

        tok.char_valid  = keep;
        tok.out_char    = keep ? ch : 8'h00;
        tok.word_end    = done;
        tok.word_length = tok_count;
        if (done)
            clear_word_state();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Checker. Everything is sampled at the rising edge, before the block's own
    // registers or the testbench's nonblocking drives take effect, so both
    // sides of a handshake are seen as they stood when the edge came.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_and_predict
        t_result want;
        t_result guess;
        bit      has_res;
        if (!i_rst_n) begin
            clear_word_state();
            tok_max_len = MAX_LEN_RESET;
            expected_tokens.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected result: char_valid %0d out_char %h word_end %0d len %0d",
                           o_char_valid, o_out_char, o_word_end, o_word_length);
                    mismatch_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_char_valid !== want.char_valid) begin
                        $error("char_valid: expected %0d, actual %0d",
                               want.char_valid, o_char_valid);
                        mismatch_count++;
                    end
                    if (o_out_char !== want.out_char) begin
                        $error("out_char: expected %h, actual %h", want.out_char, o_out_char);
                        mismatch_count++;
                    end
                    if (o_word_end !== want.word_end) begin
                        $error("word_end: expected %0d, actual %0d", want.word_end, o_word_end);
                        mismatch_count++;
                    end
                    if (o_word_length !== want.word_length) begin
                        $error("word_length: expected %0d, actual %0d",
                               want.word_length, o_word_length);
                        mismatch_count++;
                    end
                end
            end

            // The predictor always advances, even for rows whose answer is typed in,
            // so that its state stays in step with the block.
            if (i_in_valid && !o_in_stall) begin
                has_res = tokenize_byte(i_in_char, i_line_end, guess);
                if (row_typed)
                    expected_tokens.push_back(row_want);
                else if (has_res)
                    expected_tokens.push_back(guess);
            end

            if (i_cfg_wr_en)
                tok_max_len = i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // Result-side back-pressure. A new mode is drawn whenever the 6-bit tick wraps: no stall,
    // light random stall, heavy random stall, or a fixed stall while tick bits 3:2 are both set.
    // ------------------------------------------------------------------------
    logic [5:0] stall_tick = 6'd0;
    logic [1:0] stall_mode = 2'd0;

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 6'd1;
        if (stall_tick == 6'd0)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0:    i_out_stall <= 1'b0;
            2'd1:    i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2:    i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_tick[3:2] == 2'b11);
        endcase
    end

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int items_sent = 0;

    // Presents one request and returns at the edge where it is taken.
    task automatic send_req(input logic [7:0] c, input logic eol,
                            input logic typed, input t_result want);
        i_in_valid <= 1'b1;
        i_in_char  <= c;
        i_line_end <= eol;
        row_typed  <= typed;
        row_want   <= want;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Bursts of back-to-back requests separated by idle gaps of random length;
    // about a quarter of the bursts follow the previous one with no gap at all.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    // Lets the block run dry: every expected result in, then an extra wait for
    // requests that are still in the pipeline but give no result.
    task automatic wait_idle();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_max_len(input logic [7:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Byte mix for well-formed command lines: mostly letters, with blanks,
    // quotes, backslashes, escape letters, the odd NUL and fully random bytes.
    function automatic logic [7:0] pick_byte();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            b = 8'($urandom_range(8'h61, 8'h7A));
        end else if (r < 57) begin
            r = $urandom_range(0, 5);
            b = (r == 5) ? CH_SPACE : 8'(8'h09 + r);
        end else if (r < 65) begin
            b = CH_BACKSLASH;
        end else if (r < 71) begin
            b = CH_SQUOTE;
        end else if (r < 77) begin
            b = CH_DQUOTE;
        end else if (r < 80) begin
            b = CH_NUL;
        end else if (r < 88) begin
            case ($urandom_range(0, 5))
                0:       b = CH_LOW_N;
                1:       b = CH_LOW_T;
                2:       b = CH_LOW_R;
                3:       b = CH_LOW_B;
                4:       b = CH_LOW_F;
                default: b = CH_LOW_V;
            endcase
        end else begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    // One command line; one in ten is pure noise, and lines may well end with
    // a quote or an escape still open.
    task automatic send_random_line();
        int         n;
        bit         noisy;
        logic [7:0] b;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 60) : $urandom_range(1, 20);
        noisy = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n; k++) begin
            b = noisy ? 8'($urandom_range(0, 255)) : pick_byte();
            send_req(b, (k == n - 1), 1'b0, '0);
            pace_sender();
        end
    endtask

    task automatic run_phase(input logic [7:0] limit, input int count);
        int target;
        set_max_len(limit);
        target = items_sent + count;
        while (items_sent < target)
            send_random_line();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows run at the reset limit of 255.
        for (int i = 0; i < N_DIR; i++) begin
            send_req(DIR_ROWS[i].in_char, DIR_ROWS[i].eol, DIR_ROWS[i].typed,
                     DIR_ROWS[i].want);
            pace_sender();
        end

        // Tight limits first: one and zero end every word on its first kept byte; zero acts as one.
        run_phase(8'd1, 55);
        run_phase(8'd0, 55);
        run_phase(8'd2, 55);
        run_phase(8'd5, 55);
        run_phase(8'd254, 40);

        // One long word at the top limit: byte 255 hits it, byte 256 opens a new
        // word that the line end closes at once.
        set_max_len(8'd255);
        for (int k = 0; k < 256; k++) begin
            send_req(8'($urandom_range(8'h61, 8'h7A)), (k == 255), 1'b0, '0);
            pace_sender();
        end

        run_phase(8'($urandom_range(1, 255)), 55);
        run_phase(8'($urandom_range(1, 16)), 55);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (expected_tokens.size() != 0)
                $error("%0d expected results never arrived", expected_tokens.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
